>>> rtl/core/lplg_pkg.sv
// ----------------------------------------------------------------------------
// lplg_pkg: shared types and constants for the long-press latch gate
// Request and result payloads, register indexes and time-width constants.
// ----------------------------------------------------------------------------
package lplg_pkg;

	// Timestamp width actually used (16..64); now_ms keeps its full 64 bits.
	localparam int TIME_BITS = 64;
	localparam int CFG_W     = 32;
	// Width that holds both a timestamp and a 32-bit register value.
	localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
	localparam int SUM_W     = CMP_W + 1;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	localparam logic [CFG_W-1:0] SAMPLE_INTERVAL_RST = 32'd10;
	localparam logic [CFG_W-1:0] HOLD_TIME_RST       = 32'd3000;

	typedef enum logic [0:0] {
		REG_SAMPLE_INTERVAL = 1'b0,
		REG_HOLD_TIME       = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'b001,
		MODE_PENDING = 3'b010,
		MODE_LATCHED = 3'b100
	} gate_mode_t;

	typedef struct packed {
		logic [63:0] now_ms;
		logic        pressed;
	} sample_t;

	typedef struct packed {
		logic        status;
		logic        activated;
		logic        latched;
		logic [63:0] next_deadline;
	} result_t;

endpackage

>>> rtl/core/long_press_latch_gate.sv
// ----------------------------------------------------------------------------
// long_press_latch_gate: rate-limited long-press detector with a sticky latch
// Takes timestamped button samples, drops those that are not yet due, and
// latches for good once a press has been held for hold_time milliseconds.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  sample    in         sample_valid / sample_ready  sample_t (now_ms, pressed)
//  result    out        result_valid / result_ready  result_t (status, activated,
//                                                      latched, next_deadline)
//  cfg       in         cfg_write                    cfg_index, cfg_data
//
//  One request per cycle sustained while results are taken; result_valid
//  rises once the request has passed the input register and then the
//  result register.
//  The whole per-request update (64-bit compares, one saturating add, one
//  subtract) sits between the s1 register and the result register.
//  Reset (arst_n low) clears the gate state and loads the register defaults.
//  A stalled result holds both stages; s1 still takes a request while the
//  result register is full but about to be taken.
//
module long_press_latch_gate
	import lplg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               sample_valid,
	output logic               sample_ready,
	input  sample_t            sample,

	output logic               result_valid,
	input  logic               result_ready,
	output result_t            result,

	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	// configuration
	logic [CFG_W-1:0]     sample_interval_q;
	logic [CFG_W-1:0]     hold_time_q;

	// gate state
	gate_mode_t           mode_q;
	logic                 seen_q;
	logic [TIME_BITS-1:0] last_time_q;
	logic [TIME_BITS-1:0] due_time_q;
	logic [TIME_BITS-1:0] press_start_q;

	// stage 1: accepted request
	logic                 valid_s1;
	sample_t              sample_s1;

	// result register
	logic                 result_valid_q;
	result_t              result_q;

	logic                 advance;

	// next-state logic
	logic [TIME_BITS-1:0] now;
	logic                 backwards;
	logic                 due;
	logic [SUM_W-1:0]     dl_sum;
	logic [TIME_BITS-1:0] dl_next;
	logic [TIME_BITS-1:0] held;
	logic                 hold_met;

	gate_mode_t           mode_d;
	logic                 seen_d;
	logic [TIME_BITS-1:0] last_time_d;
	logic [TIME_BITS-1:0] due_time_d;
	logic [TIME_BITS-1:0] press_start_d;
	logic                 status_d;
	logic                 activated_d;

	// s1 moves on when the result register is free or being emptied
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_interval_q <= SAMPLE_INTERVAL_RST;
			hold_time_q       <= HOLD_TIME_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SAMPLE_INTERVAL: sample_interval_q <= cfg_data;
				REG_HOLD_TIME:       hold_time_q       <= cfg_data;
				default:             ;
			endcase
		end
	end

	always_comb begin
		now       = sample_s1.now_ms[TIME_BITS-1:0];
		backwards = seen_q && (now < last_time_q);
		// due: first sample, time went back, or deadline reached; a last
		// sample at the time maximum blocks all but a step backwards
		due       = !seen_q || backwards ||
			((last_time_q != TIME_MAX) && (now >= due_time_q));

		// saturating deadline
		dl_sum  = SUM_W'(now) + SUM_W'(sample_interval_q);
		dl_next = (dl_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : dl_sum[TIME_BITS-1:0];

		held     = now - press_start_q;
		hold_met = CMP_W'(held) >= CMP_W'(hold_time_q);

		mode_d        = mode_q;
		seen_d        = seen_q;
		last_time_d   = last_time_q;
		due_time_d    = due_time_q;
		press_start_d = press_start_q;
		status_d      = 1'b0;
		activated_d   = 1'b0;

		if (mode_q == MODE_LATCHED) begin
			// frozen, always ok
		end else if (!due) begin
			status_d = 1'b1;
		end else begin
			seen_d      = 1'b1;
			last_time_d = now;
			due_time_d  = dl_next;
			if (!sample_s1.pressed) begin
				mode_d        = MODE_IDLE;
				press_start_d = '0;
			end else if (backwards || mode_q != MODE_PENDING) begin
				// a backwards step drops tracking, so this is a first press
				mode_d        = MODE_PENDING;
				press_start_d = now;
			end else if (hold_met) begin
				mode_d      = MODE_LATCHED;
				activated_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_IDLE;
			seen_q         <= 1'b0;
			last_time_q    <= '0;
			due_time_q     <= '0;
			press_start_q  <= '0;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (advance) begin
				mode_q         <= mode_d;
				seen_q         <= seen_d;
				last_time_q    <= last_time_d;
				due_time_q     <= due_time_d;
				press_start_q  <= press_start_d;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
		if (advance) begin
			result_q.status        <= status_d;
			result_q.activated     <= activated_d;
			result_q.latched       <= (mode_d == MODE_LATCHED);
			result_q.next_deadline <= 64'(due_time_d);
		end
	end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the long-press latch gate
// Streams timestamped button requests through the block. A scoreboard keeps
// its own copy of the gate state and the two registers, predicts one result
// per accepted request and checks results in order. Both sides idle at
// random, and the registers are swept between phases.
// ----------------------------------------------------------------------------
module tb_top
	import lplg_pkg::*;
();

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 5;
	localparam int DRAIN_CYCLES   = 4;     // result path is two stages deep
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all

	// ------------------------------------------------------------------------
	// Scoreboard: gate state mirror and the queue of results still due
	// ------------------------------------------------------------------------
	class gate_scoreboard;
		logic [CFG_W-1:0]     interval_ms;
		logic [CFG_W-1:0]     hold_ms;
		gate_mode_t           mode;
		bit                   seen;
		logic [TIME_BITS-1:0] last_t;
		logic [TIME_BITS-1:0] due_t;
		logic [TIME_BITS-1:0] press_t;
		result_t              expected_q[$];
		int                   errors;

		function new();
			interval_ms = SAMPLE_INTERVAL_RST;
			hold_ms     = HOLD_TIME_RST;
			mode        = MODE_IDLE;
			seen        = 1'b0;
			last_t      = '0;
			due_t       = '0;
			press_t     = '0;
			errors      = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
			if (idx == REG_SAMPLE_INTERVAL)
				interval_ms = val;
			else
				hold_ms = val;
		endfunction

		// Works out the result of one request; commit updates the mirror.
		function result_t predict(sample_t s, bit commit);
			logic [TIME_BITS-1:0] now_t;
			logic [TIME_BITS-1:0] last_n;
			logic [TIME_BITS-1:0] due_n;
			logic [TIME_BITS-1:0] press_n;
			logic [TIME_BITS-1:0] elapsed;
			logic [SUM_W-1:0]     sum;
			gate_mode_t           mode_n;
			bit                   due_ok;
			result_t              r;
			now_t   = s.now_ms[TIME_BITS-1:0];
			mode_n  = mode;
			last_n  = last_t;
			due_n   = due_t;
			press_n = press_t;
			r       = '0;
			if (mode != MODE_LATCHED) begin
				// a sample stamped at the time maximum blocks everything but
				// a step backwards
				due_ok = !seen || now_t < last_t ||
					(last_t != TIME_MAX && now_t >= due_t);
				if (!due_ok) begin
					r.status = 1'b1;
				end else begin
					if (seen && now_t < last_t) begin
						mode_n  = MODE_IDLE;
						press_n = '0;
					end
					last_n = now_t;
					sum    = SUM_W'(now_t) + SUM_W'(interval_ms);
					due_n  = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
					if (!s.pressed) begin
						mode_n  = MODE_IDLE;
						press_n = '0;
					end else if (mode_n != MODE_PENDING) begin
						mode_n  = MODE_PENDING;
						press_n = now_t;
					end else begin
						elapsed = now_t - press_n;
						if (CMP_W'(elapsed) >= CMP_W'(hold_ms)) begin
							mode_n      = MODE_LATCHED;
							r.activated = 1'b1;
						end
					end
				end
			end
			r.latched       = (mode_n == MODE_LATCHED);
			r.next_deadline = 64'(due_n);
			if (commit) begin
				if (mode != MODE_LATCHED && !r.status)
					seen = 1'b1;
				mode    = mode_n;
				last_t  = last_n;
				due_t   = due_n;
				press_t = press_n;
			end
			return r;
		endfunction

		function void note_sample(sample_t s);
			expected_q.push_back(predict(s, 1'b1));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void report(string msg);
			errors++;
			$display("%0t: mismatch: %s", $time, msg);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with no request pending, deadline %h",
					got.next_deadline));
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.activated !== want.activated ||
					got.latched !== want.latched ||
					got.next_deadline !== want.next_deadline)
				report($sformatf({"status %b/%b activated %b/%b latched %b/%b ",
					"deadline %h/%h (want/got)"},
					want.status, got.status, want.activated, got.activated,
					want.latched, got.latched, want.next_deadline, got.next_deadline));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and its drivers
	// ------------------------------------------------------------------------
	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             sample_valid = 1'b0;
	logic             sample_ready;
	sample_t          sample       = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	result_t          result;
	logic             cfg_write    = 1'b0;
	logic             cfg_index    = 1'b0;
	logic [CFG_W-1:0] cfg_data     = '0;

	gate_scoreboard   sb;
	int               send_idle    = 0;   // percent of cycles the sender idles
	int               recv_stall   = 0;   // percent of cycles the receiver stalls
	int               quiet_cycles = 0;
	logic [63:0]      t_cursor;           // timestamp of the last due request
	logic [CFG_W-1:0] cur_interval = SAMPLE_INTERVAL_RST;
	logic [CFG_W-1:0] cur_hold     = HOLD_TIME_RST;

	long_press_latch_gate i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Result side: check each taken result, randomize ready for the next cycle.
	// Everything is sampled right at the edge, i.e. before the DUT's flops move.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(result);
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		result_ready <= ($urandom_range(99) >= recv_stall);
	end

	// Watchdog: the run is hung if no handshake happens for too long.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("tb_top: FAIL");
		$finish;
	end

	// Offer one request, idling first at the phase's rate. Valid stays high
	// across back-to-back requests, so it is only lowered when a gap is taken.
	task automatic send_sample(sample_t s);
		if ($urandom_range(99) < send_idle) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
		sb.note_sample(s);
	endtask

	// Stop sending and let every predicted result come back.
	task automatic hold_off();
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Both registers back to back, only while the gate is idle.
	task automatic load_regs(logic [CFG_W-1:0] interval_v, logic [CFG_W-1:0] hold_v);
		cfg_write <= 1'b1;
		cfg_index <= REG_SAMPLE_INTERVAL;
		cfg_data  <= interval_v;
		@(posedge clk);
		cfg_index <= REG_HOLD_TIME;
		cfg_data  <= hold_v;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_reg(REG_SAMPLE_INTERVAL, interval_v);
		sb.set_reg(REG_HOLD_TIME, hold_v);
		cur_interval = interval_v;
		cur_hold     = hold_v;
	endtask

	function automatic sample_t mk(logic [63:0] now, logic pressed);
		sample_t s;
		s.now_ms  = now;
		s.pressed = pressed;
		return s;
	endfunction

	// Random phase. Most requests walk forward from the last due timestamp
	// by about one interval, so presses build up; the rest go backwards or
	// are plain noise. Unless may_latch is set, a press that would latch is
	// turned into a release: the latch is permanent and reset happens once.
	task automatic run_phase(int n, int s_idle, int r_stall, bit may_latch);
		sample_t s;
		result_t r;
		int      pick;
		send_idle  = s_idle;
		recv_stall = r_stall;
		case ($urandom_range(2))
			0: t_cursor = 64'($urandom_range(1000));
			1: t_cursor = {$urandom, $urandom};
			default: t_cursor = TIME_MAX - 64'(cur_interval) * $urandom_range(3)
				- $urandom_range(5);
		endcase
		for (int k = 0; k < n; k++) begin
			pick      = $urandom_range(99);
			s.pressed = ($urandom_range(99) < 80);
			if (pick < 75) begin
				case ($urandom_range(4))
					0: s.now_ms = t_cursor + cur_interval;
					1: s.now_ms = t_cursor + cur_interval + $urandom_range(1, 40);
					2: s.now_ms = t_cursor + cur_interval + $urandom_range(cur_hold);
					default: s.now_ms = (cur_interval == 0) ? t_cursor :
						t_cursor + $urandom_range(cur_interval - 1);
				endcase
			end else if (pick < 88) begin
				if ($urandom_range(1))
					s.now_ms = t_cursor - $urandom_range(1, 50);
				else
					s.now_ms = {$urandom, $urandom} >> $urandom_range(63);
			end else begin
				s.now_ms  = {$urandom, $urandom};
				s.pressed = 1'($urandom_range(1));
			end
			r = sb.predict(s, 1'b0);
			if (r.activated && !may_latch) begin
				s.pressed = 1'b0;
				r = sb.predict(s, 1'b0);
			end
			if (!r.status)
				t_cursor = s.now_ms;
			send_sample(s);
			// Pressure: drain the pipe once in the middle of every phase
			if (k == n / 2)
				hold_off();
		end
		hold_off();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed requests at the register reset values (10 ms, 3000 ms)
		send_sample(mk(64'd5, 1'b0));            // first sample is always due
		send_sample(mk(64'd14, 1'b1));           // one short of the deadline
		send_sample(mk(64'd15, 1'b1));           // right on it: press starts
		send_sample(mk(64'd20, 1'b1));           // too early again
		send_sample(mk(64'd3014, 1'b1));         // held one ms short of latching
		send_sample(mk(64'd3, 1'b1));            // backwards: tracking restarts
		send_sample(mk(64'd13, 1'b0));           // release
		send_sample(mk(TIME_MAX - 5, 1'b1));     // deadline saturates
		send_sample(mk(TIME_MAX - 1, 1'b1));     // not yet due
		send_sample(mk(TIME_MAX, 1'b1));         // due at the saturated deadline
		send_sample(mk(TIME_MAX, 1'b1));         // stuck at the maximum: blocks
		send_sample(mk(64'd0, 1'b0));            // only going backwards gets out
		send_sample(mk(64'd0, 1'b1));            // same timestamp: blocks
		send_sample(mk(64'd10, 1'b1));
		send_sample(mk({$urandom, $urandom}, 1'b0));
		hold_off();

		// Register sweep, with the idling pattern varied between phases
		load_regs('0, '1);
		run_phase(95, 0, 0, 1'b0);
		load_regs('1, $urandom);
		run_phase(95, 70, 0, 1'b0);
		load_regs($urandom_range(1, 100), $urandom_range(200));
		run_phase(95, 0, 70, 1'b0);
		load_regs($urandom, '0);
		run_phase(95, 20, 20, 1'b0);
		load_regs(SAMPLE_INTERVAL_RST, HOLD_TIME_RST);
		run_phase(95, 0, 0, 1'b0);
		load_regs($urandom_range(20), $urandom_range(60));
		run_phase(95, 0, 70, 1'b0);
		// Last: zero hold time lets the gate latch, then it must stay frozen
		load_regs($urandom_range(10), '0);
		run_phase(60, 20, 20, 1'b1);

		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

>>> long_press_latch_gate.f
rtl/core/lplg_pkg.sv
rtl/core/long_press_latch_gate.sv
tb/tb_top.sv
